// ----- sv/rv32im_pkg.sv -----
// Package for the RV32IM integer execute unit.
// Holds operation codes, payload types and shared constants; no dependencies.
package rv32im_pkg;

    localparam int XLEN = 32;
    localparam int REG_AW = 5;

    typedef enum logic [4:0] {
        OP_ADD    = 5'd0,
        OP_SUB    = 5'd1,
        OP_XOR    = 5'd2,
        OP_OR     = 5'd3,
        OP_AND    = 5'd4,
        OP_SLL    = 5'd5,
        OP_SRL    = 5'd6,
        OP_SRA    = 5'd7,
        OP_SLT    = 5'd8,
        OP_SLTU   = 5'd9,
        OP_MUL    = 5'd10,
        OP_MULH   = 5'd11,
        OP_MULHSU = 5'd12,
        OP_MULHU  = 5'd13,
        OP_DIV    = 5'd14,
        OP_DIVU   = 5'd15,
        OP_REM    = 5'd16,
        OP_REMU   = 5'd17
    } op_t;

    localparam logic [4:0] OP_LAST = 5'd17;

    typedef struct packed {
        logic [4:0]         func;
        logic [4:0]         dest_reg;
        logic [4:0]         src1_reg;
        logic [4:0]         src2_reg;
        logic               use_imm;
        logic signed [11:0] imm_value;
    } in_item_t;

    typedef struct packed {
        logic [4:0]         written_reg;
        logic signed [31:0] result_value;
        logic               write_done;
        logic               bad_op;
    } out_item_t;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;   // capture input item
        logic load_ops;    // capture operands from register file read
        logic mul_lo;      // first multiply pass
        logic mul_hi;      // second multiply pass
        logic div_start;   // set up divider
        logic div_step;    // one restoring step
        logic finish;      // form result, write register file, fill output
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_bad;
        logic is_mul;
        logic is_div;
        logic div_last;
    } dp_stat_t;

endpackage

// ----- sv/rv32im_item_if.sv -----
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; the payload type is a parameter.
interface rv32im_item_if #(
    parameter type PAYLOAD_T = logic
);
    logic     valid;
    logic     ready;
    PAYLOAD_T data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/rv32im_integer_execute_unit.sv -----
// RV32IM integer execute unit: 32 x 32-bit register file plus ALU, multiplier, divider.
// Each item goes through the read, execute and finish steps; multiplies add a second pass
// and divide and remainder take 32 restoring steps of one shared divider.
// One item at a time; the next item is taken in idle, after the result is registered.
// Reset clears control and the register file written bits, so all registers read zero.
module rv32im_integer_execute_unit (
    input logic   clk,
    input logic   rst_n,
    rv32im_item_if.sink   in_ch,
    rv32im_item_if.source out_ch
);
    import rv32im_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller sequences read, execute, iterate and finish steps.
    rv32im_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the register file and all arithmetic units.
    rv32im_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_ch.data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_ch.data)
    );
endmodule

// ----- sv/rv32im_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rv32im_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- sv/rv32im_ctrl.sv -----
// Controller state machine of the execute unit.
// Depends on rv32im_pkg; drives datapath commands and the channel handshakes.
module rv32im_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rv32im_pkg::dp_stat_t stat,
    output rv32im_pkg::dp_cmd_t  cmd
);
    import rv32im_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ1,
        S_READ2,
        S_EXEC,
        S_MUL2,
        S_DIV,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // A new item is taken only in idle; the output register frees on its own.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = S_READ1;
                end
            end
            S_READ1:
            begin
                state_next = S_READ2;
            end
            S_READ2:
            begin
                cmd.load_ops = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (stat.is_mul && !stat.is_bad)
                begin
                    cmd.mul_lo = 1'b1;
                    state_next = S_MUL2;
                end
                else if (stat.is_div && !stat.is_bad)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL2:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_DONE;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule

// ----- sv/rv32im_dpath.sv -----
// Datapath of the execute unit: register file, ALU, two-pass multiplier,
// restoring divider and output register. Depends on rv32im_pkg and rv32im_ram.
module rv32im_dpath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rv32im_pkg::in_item_t  in_data,
    input  rv32im_pkg::dp_cmd_t   cmd,
    output rv32im_pkg::dp_stat_t  stat,
    output rv32im_pkg::out_item_t out_data
);
    import rv32im_pkg::*;

    in_item_t         item_reg;
    logic [XLEN-1:0]  a_reg, b_reg;
    logic [XLEN-1:0]  res_reg, res_next;
    out_item_t        out_reg;

    // Two RAM copies give two read ports; both take every write.
    logic [XLEN-1:0]  rd1_data, rd2_data;
    logic [XLEN-1:0]  rf_wdata;
    logic             rf_we;
    // Register file starts undefined, so a per-entry written bit gives zero.
    logic [31:0]      written_reg_bits;

    rv32im_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf1 (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (item_reg.dest_reg),
        .wr_data (rf_wdata),
        .rd_addr (item_reg.src1_reg),
        .rd_data (rd1_data)
    );
    rv32im_ram #(.WIDTH(XLEN), .DEPTH(32)) u_rf2 (
        .clk     (clk),
        .wr_en   (rf_we),
        .wr_addr (item_reg.dest_reg),
        .wr_data (rf_wdata),
        .rd_addr (item_reg.src2_reg),
        .rd_data (rd2_data)
    );

    logic bad;
    assign bad = (item_reg.func > OP_LAST);
    assign stat.is_bad = bad;
    assign stat.is_mul = (item_reg.func inside {OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU});
    assign stat.is_div = (item_reg.func inside {OP_DIV, OP_DIVU, OP_REM, OP_REMU});

    logic use_imm_eff;
    assign use_imm_eff = item_reg.use_imm && (item_reg.func <= OP_SLTU);

    // Combinational ALU for the operations other than multiply and divide.
    logic [XLEN-1:0] alu;
    logic [4:0]      sh;
    assign sh = b_reg[4:0];
    always_comb
    begin
        case (op_t'(item_reg.func))
            OP_ADD:  alu = a_reg + b_reg;
            OP_SUB:  alu = a_reg - b_reg;
            OP_XOR:  alu = a_reg ^ b_reg;
            OP_OR:   alu = a_reg | b_reg;
            OP_AND:  alu = a_reg & b_reg;
            OP_SLL:  alu = a_reg << sh;
            OP_SRL:  alu = a_reg >> sh;
            OP_SRA:  alu = XLEN'($signed(a_reg) >>> sh);
            OP_SLT:  alu = {31'd0, $signed(a_reg) < $signed(b_reg)};
            OP_SLTU: alu = {31'd0, a_reg < b_reg};
            default: alu = '0;
        endcase
    end

    // Multiplier: magnitudes in the first pass, a times both 16-bit halves of b in the second, sign fixed after.
    logic             a_sgn, b_sgn, neg_reg;
    logic [XLEN-1:0]  ma_reg, mb_reg;
    logic [63:0]      prod_reg;
    logic [47:0]      pp;
    logic [47:0]      pp_lo;
    assign a_sgn = (item_reg.func == OP_MULH || item_reg.func == OP_MULHSU) && a_reg[31];
    assign b_sgn = (item_reg.func == OP_MULH) && b_reg[31];
    assign pp = ma_reg * (cmd.mul_hi ? mb_reg[31:16] : mb_reg[15:0]);
    assign pp_lo = ma_reg * mb_reg[15:0];

    logic [63:0] prod_fix;
    assign prod_fix = neg_reg ? (~prod_reg + 64'd1) : prod_reg;

    // Restoring divider on magnitudes.
    logic [XLEN-1:0] quo_reg, rem_reg, dvs_reg, dvd_reg;
    logic [5:0]      cnt_reg;
    logic            qneg_reg, rneg_reg, dzero_reg;
    logic [XLEN:0]   trial;
    assign trial = {rem_reg, quo_reg[31]} - {1'b0, dvs_reg};
    assign stat.div_last = (cnt_reg == 6'd31);

    logic is_signed_div;
    assign is_signed_div = (item_reg.func == OP_DIV || item_reg.func == OP_REM);

    always_comb
    begin
        res_next = alu;
        if (stat.is_mul)
        begin
            res_next = (item_reg.func == OP_MUL) ? prod_fix[31:0] : prod_fix[63:32];
        end
        else if (stat.is_div)
        begin
            if (dzero_reg)
            begin
                res_next = (item_reg.func == OP_DIV || item_reg.func == OP_DIVU)
                           ? '1 : dvd_reg;
            end
            else if (item_reg.func == OP_DIV || item_reg.func == OP_DIVU)
            begin
                res_next = qneg_reg ? (~quo_reg + 32'd1) : quo_reg;
            end
            else
            begin
                res_next = rneg_reg ? (~rem_reg + 32'd1) : rem_reg;
            end
        end
        if (bad)
        begin
            res_next = '0;
        end
    end

    assign rf_we    = cmd.finish && !bad && (item_reg.dest_reg != 5'd0);
    assign rf_wdata = res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg_bits <= '0;
        end
        else if (rf_we)
        begin
            written_reg_bits[item_reg.dest_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_data;
        end
        if (cmd.load_ops)
        begin
            a_reg <= written_reg_bits[item_reg.src1_reg] ? rd1_data : '0;
            if (use_imm_eff)
            begin
                b_reg <= XLEN'(signed'(item_reg.imm_value));
            end
            else
            begin
                b_reg <= written_reg_bits[item_reg.src2_reg] ? rd2_data : '0;
            end
        end
        if (cmd.mul_lo)
        begin
            ma_reg <= a_sgn ? (~a_reg + 32'd1) : a_reg;
            mb_reg <= b_sgn ? (~b_reg + 32'd1) : b_reg;
            neg_reg <= a_sgn ^ b_sgn;
        end
        if (cmd.mul_hi)
        begin
            prod_reg <= {16'd0, pp_lo} + {pp, 16'd0};
        end
        if (cmd.div_start)
        begin
            quo_reg   <= (is_signed_div && a_reg[31]) ? (~a_reg + 32'd1) : a_reg;
            dvs_reg   <= (is_signed_div && b_reg[31]) ? (~b_reg + 32'd1) : b_reg;
            dvd_reg   <= a_reg;
            rem_reg   <= '0;
            cnt_reg   <= '0;
            qneg_reg  <= is_signed_div && (a_reg[31] ^ b_reg[31]);
            rneg_reg  <= is_signed_div && a_reg[31];
            dzero_reg <= (b_reg == '0);
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (!trial[XLEN])
            begin
                rem_reg <= trial[XLEN-1:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[30:0], quo_reg[31]};
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.finish)
        begin
            out_reg.written_reg  <= item_reg.dest_reg;
            out_reg.result_value <= res_next;
            out_reg.write_done   <= rf_we;
            out_reg.bad_op       <= bad;
        end
    end

    assign out_data = out_reg;
endmodule

// ----- test/tb_rv32im_results.sv -----
// Scoreboard for the RV32IM execute unit testbench: predicts each result from a
// private copy of the register file and checks the block's results in order.
// Depends on rv32im_pkg.
class rv32im_result_board;

    logic [31:0]                   regs [32];
    rv32im_pkg::out_item_t         pending [$];
    int                            errors;

    function new();
        foreach (regs[i]) regs[i] = '0;
        errors = 0;
    endfunction

    // Works out the value of one operation on two 32-bit operands.
    function logic [31:0] alu(rv32im_pkg::op_t op, logic [31:0] a, logic [31:0] b);
        logic signed [63:0] sa;
        logic signed [63:0] sb;
        logic [63:0]        prod;
        logic [4:0]         sh;
        sa = {{32{a[31]}}, a};
        sb = {{32{b[31]}}, b};
        sh = b[4:0];
        case (op)
            rv32im_pkg::OP_ADD:    return a + b;
            rv32im_pkg::OP_SUB:    return a - b;
            rv32im_pkg::OP_XOR:    return a ^ b;
            rv32im_pkg::OP_OR:     return a | b;
            rv32im_pkg::OP_AND:    return a & b;
            rv32im_pkg::OP_SLL:    return a << sh;
            rv32im_pkg::OP_SRL:    return a >> sh;
            rv32im_pkg::OP_SRA:    return $signed(a) >>> sh;
            rv32im_pkg::OP_SLT:    return (sa < sb) ? 32'd1 : 32'd0;
            rv32im_pkg::OP_SLTU:   return (a < b) ? 32'd1 : 32'd0;
            rv32im_pkg::OP_MUL:    return a * b;
            rv32im_pkg::OP_MULH:
            begin
                prod = sa * sb;
                return prod[63:32];
            end
            rv32im_pkg::OP_MULHSU:
            begin
                prod = sa * $signed({32'd0, b});
                return prod[63:32];
            end
            rv32im_pkg::OP_MULHU:
            begin
                prod = {32'd0, a} * {32'd0, b};
                return prod[63:32];
            end
            rv32im_pkg::OP_DIV:
            begin
                if (b == 0) return '1;
                prod = sa / sb;
                return prod[31:0];
            end
            rv32im_pkg::OP_DIVU:   return (b == 0) ? '1 : a / b;
            rv32im_pkg::OP_REM:
            begin
                if (b == 0) return a;
                prod = sa % sb;
                return prod[31:0];
            end
            rv32im_pkg::OP_REMU:   return (b == 0) ? a : a % b;
            default:               return '0;
        endcase
    endfunction

    function void note_input(rv32im_pkg::in_item_t it);
        rv32im_pkg::out_item_t exp_r;
        logic [31:0]           b;
        exp_r.written_reg = it.dest_reg;
        exp_r.result_value = '0;
        exp_r.write_done = 1'b0;
        exp_r.bad_op = 1'b0;
        if (it.func > rv32im_pkg::OP_LAST) begin
            exp_r.bad_op = 1'b1;
        end else begin
            if (it.use_imm && it.func <= rv32im_pkg::OP_SLTU)
                b = {{20{it.imm_value[11]}}, it.imm_value};
            else
                b = regs[it.src2_reg];
            exp_r.result_value = alu(rv32im_pkg::op_t'(it.func), regs[it.src1_reg], b);
            if (it.dest_reg != 0) begin
                regs[it.dest_reg] = exp_r.result_value;
                exp_r.write_done = 1'b1;
            end
        end
        pending.push_back(exp_r);
    endfunction

    function void check_result(rv32im_pkg::out_item_t got);
        rv32im_pkg::out_item_t exp_r;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %p", $time, got);
            errors++;
            return;
        end
        exp_r = pending.pop_front();
        if (got.written_reg !== exp_r.written_reg) begin
            $display("%0t: written_reg expected %0d actual %0d", $time,
                     exp_r.written_reg, got.written_reg);
            errors++;
        end
        if (got.result_value !== exp_r.result_value) begin
            $display("%0t: result_value expected %h actual %h", $time,
                     exp_r.result_value, got.result_value);
            errors++;
        end
        if (got.write_done !== exp_r.write_done) begin
            $display("%0t: write_done expected %b actual %b", $time,
                     exp_r.write_done, got.write_done);
            errors++;
        end
        if (got.bad_op !== exp_r.bad_op) begin
            $display("%0t: bad_op expected %b actual %b", $time, exp_r.bad_op, got.bad_op);
            errors++;
        end
    endfunction

endclass

// ----- test/tb_top.sv -----
// Top-level testbench for rv32im_integer_execute_unit: directed and random items
// with random idling on both channels, checked by rv32im_result_board.
// Depends on rv32im_pkg, rv32im_item_if and tb_rv32im_results.sv.
module tb_top;
    import rv32im_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 800;

    logic clk;
    logic rst_n;
    int   cycles;

    // Idling is turned off for a stretch in the middle of the random part.
    bit   calm;

    rv32im_item_if #(.PAYLOAD_T(in_item_t))  in_ch ();
    rv32im_item_if #(.PAYLOAD_T(out_item_t)) out_ch ();

    rv32im_result_board board;

    rv32im_integer_execute_unit u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The run is stopped hard if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Results are sampled at the rising edge; ready changes at the falling edge,
    // and is held low at random about 36 percent of the time unless idling is off.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.data);
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 36);
    end

    // Offers one item and returns at the falling edge after it has been accepted,
    // with valid still high. Idle cycles are inserted before the offer at random.
    task automatic send_item(in_item_t it);
        while (!calm && $urandom_range(99) < 36)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do
            @(posedge clk);
        while (!in_ch.ready);
        board.note_input(it);
        @(negedge clk);
    endtask

    function automatic in_item_t make_item(op_t op, int rd, int rs1, int rs2, int imm,
                                           logic [11:0] immv);
        in_item_t it;
        it.func = op;
        it.dest_reg = 5'(rd);
        it.src1_reg = 5'(rs1);
        it.src2_reg = 5'(rs2);
        it.use_imm = 1'(imm);
        it.imm_value = immv;
        return it;
    endfunction

    // Random item: mostly register operands drawn from all 32 registers so that values
    // chain through the register file, with immediates of every bit pattern.
    function automatic in_item_t random_item();
        in_item_t it;
        it.func = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 18))
                                            : 5'($urandom_range(17));
        it.dest_reg = 5'($urandom_range(31));
        it.src1_reg = 5'($urandom_range(31));
        it.src2_reg = 5'($urandom_range(31));
        it.use_imm = 1'($urandom_range(1));
        case ($urandom_range(3))
            0: it.imm_value = 12'h800;
            1: it.imm_value = 12'h7ff;
            default: it.imm_value = 12'($urandom);
        endcase
        return it;
    endfunction

    initial
    begin
        in_item_t it;
        int       wait_cycles;
        board = new();
        rst_n = 1'b0;
        cycles = 0;
        calm = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: build extreme values, then each special case.
        send_item(make_item(OP_ADD, 1, 0, 0, 1, 12'h7ff));       // x1 = 2047
        send_item(make_item(OP_ADD, 2, 0, 0, 1, 12'h800));       // x2 = -2048
        send_item(make_item(OP_SLL, 3, 2, 0, 1, 12'd20));        // x3 = 0x80000000
        send_item(make_item(OP_ADD, 4, 0, 0, 1, 12'hfff));       // x4 = -1
        send_item(make_item(OP_XOR, 5, 3, 4, 0, 12'd0));         // x5 = 0x7fffffff
        send_item(make_item(OP_DIV, 6, 3, 4, 0, 12'd0));         // signed overflow
        send_item(make_item(OP_REM, 7, 3, 4, 0, 12'd0));         // overflow remainder
        send_item(make_item(OP_DIV, 8, 5, 0, 0, 12'd0));         // divide by zero
        send_item(make_item(OP_DIVU, 8, 5, 0, 0, 12'd0));
        send_item(make_item(OP_REM, 9, 2, 0, 0, 12'd0));
        send_item(make_item(OP_REMU, 9, 4, 0, 0, 12'd0));
        send_item(make_item(OP_SRA, 10, 3, 0, 1, 12'h03f));      // shift masked to 31
        send_item(make_item(OP_SRL, 11, 4, 1, 0, 12'd0));        // 2047 masks to 31
        send_item(make_item(OP_SUB, 12, 3, 1, 0, 12'd0));
        send_item(make_item(OP_OR, 13, 1, 2, 0, 12'd0));
        send_item(make_item(OP_AND, 14, 4, 0, 1, 12'h555));
        send_item(make_item(OP_SLT, 15, 3, 5, 0, 12'd0));
        send_item(make_item(OP_SLTU, 16, 1, 0, 1, 12'hfff));     // unsigned vs sext imm
        send_item(make_item(OP_MUL, 17, 4, 5, 1, 12'd0));        // imm ignored for M ops
        send_item(make_item(OP_MULH, 18, 3, 3, 0, 12'd0));
        send_item(make_item(OP_MULHSU, 19, 4, 4, 0, 12'd0));
        send_item(make_item(OP_MULHU, 20, 4, 4, 0, 12'd0));
        send_item(make_item(OP_ADD, 0, 1, 1, 0, 12'd0));         // write to x0
        send_item(make_item(OP_ADD, 21, 0, 0, 1, 12'd5));        // x0 still zero
        send_item(make_item(op_t'(5'd31), 22, 1, 2, 0, 12'd0));  // unknown operation
        in_ch.valid <= 1'b0;

        // The sender holds off until every expected result has come.
        while (board.pending.size() != 0)
            @(negedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            calm = (n >= 300 && n < 400);
            it = random_item();
            send_item(it);
        end
        in_ch.valid <= 1'b0;
        calm = 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (50) @(negedge clk);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/rv32im_pkg.sv
sv/rv32im_item_if.sv
sv/rv32im_ram.sv
sv/rv32im_ctrl.sv
sv/rv32im_dpath.sv
sv/rv32im_integer_execute_unit.sv
test/tb_rv32im_results.sv
test/tb_top.sv
